FILE: design/pfi_pkg.sv
package pfi_pkg;

    // Argument and digit buffer widths
    localparam int BIN_W      = 64;
    localparam int LONG_BITS  = 32;
    localparam int INT_BITS   = 32;
    localparam int DIG_W      = 80;
    localparam int DEC_COUNT  = DIG_W / 4;
    localparam int HEX_COUNT  = DIG_W / 4;
    localparam int OCT_COUNT  = DIG_W / 3;
    localparam int OCT_PAD    = DIG_W % 3;
    localparam int CNT_W      = $clog2(BIN_W + 1);

    localparam logic [BIN_W-1:0] INT_MASK  = (BIN_W'(1) << INT_BITS) - BIN_W'(1);
    localparam logic [BIN_W-1:0] LONG_MASK =
        (LONG_BITS >= BIN_W) ? {BIN_W{1'b1}} : ((BIN_W'(1) << LONG_BITS) - BIN_W'(1));

    // Format characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ALPHA   = 8'h57;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_XUP     = 8'h58;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_O       = 8'h6f;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2
    } radix_t;

    typedef struct packed {
        logic             start;
        radix_t           radix;
        logic             neg;
        logic [BIN_W-1:0] mag;
    } num_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } num_out_t;

    // Map a digit value to its lowercase ASCII character
    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
            r = CH_ZERO + {4'b0, d};
        else
            r = CH_ALPHA + {4'b0, d};
        return r;
    endfunction

endpackage

FILE: design/pfi_number_unit.sv
module pfi_number_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  pfi_pkg::num_cmd_t  cmd,
    input  logic               adv,
    output pfi_pkg::num_out_t  num_out
);

    typedef enum logic [3:0] {
        U_IDLE   = 4'b0001,
        U_SIGN   = 4'b0010,
        U_BCD    = 4'b0100,
        U_DIGITS = 4'b1000
    } ustate_t;

    ustate_t                        state_reg, state_next;
    logic [pfi_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           oct_reg, oct_next;
    logic                           lead_reg, lead_next;
    logic [pfi_pkg::DIG_W-1:0]      dig_reg, dig_next;
    logic [pfi_pkg::BIN_W-1:0]      bin_reg, bin_next;
    logic [pfi_pkg::DIG_W-1:0]      bcd_adj;
    logic [3:0]                     chunk;
    logic                           final_digit;
    logic                           emit;

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        bcd_adj = dig_reg;
        for (int i = 0; i < pfi_pkg::DEC_COUNT; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
        end
    end

    // Pick the top digit and decide whether it is printed
    assign chunk       = oct_reg ? {1'b0, dig_reg[pfi_pkg::DIG_W-1 -: 3]}
                                 : dig_reg[pfi_pkg::DIG_W-1 -: 4];
    assign final_digit = (cnt_reg == pfi_pkg::CNT_W'(1));
    assign emit        = (chunk != 4'd0) || !lead_reg || final_digit;

    always_comb
    begin
        num_out.valid = 1'b0;
        num_out.ch    = pfi_pkg::digit_ascii(chunk);
        num_out.last  = final_digit;
        case (state_reg)
            U_SIGN:
            begin
                num_out.valid = 1'b1;
                num_out.ch    = pfi_pkg::CH_MINUS;
                num_out.last  = 1'b0;
            end
            U_DIGITS:
                num_out.valid = emit;
            default:
                num_out.valid = 1'b0;
        endcase
    end

    // Sequence sign, binary to BCD, and digit serializing
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oct_next   = oct_reg;
        lead_next  = lead_reg;
        dig_next   = dig_reg;
        bin_next   = bin_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    lead_next = 1'b1;
                    bin_next  = cmd.mag;
                    case (cmd.radix)
                        pfi_pkg::RADIX_HEX:
                        begin
                            oct_next   = 1'b0;
                            dig_next   = pfi_pkg::DIG_W'(cmd.mag);
                            cnt_next   = pfi_pkg::CNT_W'(pfi_pkg::HEX_COUNT);
                            state_next = U_DIGITS;
                        end
                        pfi_pkg::RADIX_OCT:
                        begin
                            oct_next   = 1'b1;
                            dig_next   = pfi_pkg::DIG_W'(cmd.mag) << pfi_pkg::OCT_PAD;
                            cnt_next   = pfi_pkg::CNT_W'(pfi_pkg::OCT_COUNT);
                            state_next = U_DIGITS;
                        end
                        default:
                        begin
                            oct_next   = 1'b0;
                            dig_next   = '0;
                            cnt_next   = pfi_pkg::CNT_W'(pfi_pkg::BIN_W);
                            state_next = cmd.neg ? U_SIGN : U_BCD;
                        end
                    endcase
                end
            end
            U_SIGN:
            begin
                if (adv)
                    state_next = U_BCD;
            end
            U_BCD:
            begin
                dig_next = {bcd_adj[pfi_pkg::DIG_W-2:0], bin_reg[pfi_pkg::BIN_W-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - pfi_pkg::CNT_W'(1);
                if (final_digit)
                begin
                    cnt_next   = pfi_pkg::CNT_W'(pfi_pkg::DEC_COUNT);
                    state_next = U_DIGITS;
                end
            end
            U_DIGITS:
            begin
                if (adv)
                begin
                    dig_next = oct_reg ? (dig_reg << 3) : (dig_reg << 4);
                    cnt_next = cnt_reg - pfi_pkg::CNT_W'(1);
                    if (emit)
                        lead_next = 1'b0;
                    if (final_digit)
                        state_next = U_IDLE;
                end
            end
            default:
                state_next = U_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            oct_reg   <= 1'b0;
            lead_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oct_reg   <= oct_next;
            lead_reg  <= lead_next;
        end
    end

    // Hold digit and binary shift registers
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

endmodule

FILE: design/printf_format_interpreter_unit.sv
// Minimal printf formatter, one format byte per input transaction.
// Input channel: in_valid/in_ready carry fmt_byte and arg_value; the
// argument is consumed only when the byte completes a conversion.
// Output channel: out_valid/out_ready carry out_char, with last set on the
// final character caused by one input byte. Bytes that start or extend a
// conversion, invalid specs and the zero byte produce no output transaction.
// Steps per input byte: plain byte, %c and %% load one character;
//   %x/%p walk 20 digit positions; %o walks 26 digit positions;
//   %d/%i/%u give a minus sign for a negative signed value, then run
//   64 shift-and-add-3 steps and walk 20 digit positions.
// The digit work runs one bit or one digit per cycle through an 80-bit
// shift register, digit steps only while the output slot is free; one
// input byte is processed at a time.
// A result character sits in the output register while the receiver stalls;
// digit serializing pauses until it is taken, and in_ready stays low until
// the last character of the byte is in the output register.
// Reset returns the parser to plain text with default length and drops
// any pending output.
module printf_format_interpreter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_byte,
    input  logic [63:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CHAR = 3'b010,
        ST_NUM  = 3'b100
    } state_t;

    typedef enum logic [4:0] {
        PH_NORMAL  = 5'b00001,
        PH_PERCENT = 5'b00010,
        PH_SHORT   = 5'b00100,
        PH_LONG    = 5'b01000,
        PH_SPEC    = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        LEN_DEFAULT = 3'd0,
        LEN_HH      = 3'd1,
        LEN_H       = 3'd2,
        LEN_L       = 3'd3,
        LEN_LL      = 3'd4
    } len_t;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    len_t                      len_reg, len_next;
    logic [7:0]                char_reg, char_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_char_reg, out_char_next;
    logic                      last_reg, last_next;

    logic                      accept;
    logic                      slot_free;
    logic                      spec_go;
    logic                      char_go;
    logic                      num_go;
    logic [7:0]                char_val;
    pfi_pkg::radix_t           radix;
    logic                      is_signed;
    logic [pfi_pkg::BIN_W-1:0] mask;
    logic [pfi_pkg::BIN_W-1:0] v;
    logic                      sign_bit;
    logic                      out_load;
    pfi_pkg::num_cmd_t         cmd;
    pfi_pkg::num_out_t         num_out;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // Decode the format byte against the parser phase
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        spec_go    = 1'b0;
        char_go    = 1'b0;
        num_go     = 1'b0;
        char_val   = fmt_byte;
        radix      = pfi_pkg::RADIX_DEC;
        is_signed  = 1'b0;
        case (phase_reg)
            PH_PERCENT:
            begin
                if (fmt_byte == pfi_pkg::CH_H)
                begin
                    len_next   = LEN_H;
                    phase_next = PH_SHORT;
                end
                else if (fmt_byte == pfi_pkg::CH_L)
                begin
                    len_next   = LEN_L;
                    phase_next = PH_LONG;
                end
                else
                    spec_go = 1'b1;
            end
            PH_SHORT:
            begin
                if (fmt_byte == pfi_pkg::CH_H)
                begin
                    len_next   = LEN_HH;
                    phase_next = PH_SPEC;
                end
                else
                    spec_go = 1'b1;
            end
            PH_LONG:
            begin
                if (fmt_byte == pfi_pkg::CH_L)
                begin
                    len_next   = LEN_LL;
                    phase_next = PH_SPEC;
                end
                else
                    spec_go = 1'b1;
            end
            PH_SPEC:
                spec_go = 1'b1;
            default:
            begin
                if (fmt_byte == pfi_pkg::CH_PERCENT)
                    phase_next = PH_PERCENT;
                else
                    char_go = 1'b1;
            end
        endcase

        // Complete the conversion and drop back to plain text
        if (spec_go)
        begin
            phase_next = PH_NORMAL;
            len_next   = LEN_DEFAULT;
            case (fmt_byte)
                pfi_pkg::CH_C:
                begin
                    char_go  = 1'b1;
                    char_val = arg_value[7:0];
                end
                pfi_pkg::CH_PERCENT:
                    char_go = 1'b1;
                pfi_pkg::CH_D, pfi_pkg::CH_I:
                begin
                    num_go    = 1'b1;
                    is_signed = 1'b1;
                end
                pfi_pkg::CH_U:
                    num_go = 1'b1;
                pfi_pkg::CH_X, pfi_pkg::CH_XUP, pfi_pkg::CH_P:
                begin
                    num_go = 1'b1;
                    radix  = pfi_pkg::RADIX_HEX;
                end
                pfi_pkg::CH_O:
                begin
                    num_go = 1'b1;
                    radix  = pfi_pkg::RADIX_OCT;
                end
                default:
                    num_go = 1'b0;
            endcase
        end

        // Zero byte overrides everything
        if (fmt_byte == pfi_pkg::CH_NUL)
        begin
            phase_next = PH_NORMAL;
            len_next   = LEN_DEFAULT;
            char_go    = 1'b0;
            num_go     = 1'b0;
        end
    end

    // Mask the argument to its length and take the magnitude
    always_comb
    begin
        case (len_reg)
            LEN_LL:  mask = {pfi_pkg::BIN_W{1'b1}};
            LEN_L:   mask = pfi_pkg::LONG_MASK;
            default: mask = pfi_pkg::INT_MASK;
        endcase
        v        = arg_value & mask;
        sign_bit = |(v & (mask ^ (mask >> 1)));
        cmd.start = accept && num_go;
        cmd.radix = radix;
        cmd.neg   = is_signed && sign_bit;
        cmd.mag   = (is_signed && sign_bit) ? ((~v + pfi_pkg::BIN_W'(1)) & mask) : v;
    end

    pfi_number_unit u_number (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .adv     (slot_free && (state_reg == ST_NUM)),
        .num_out (num_out)
    );

    // Load the output register and advance the control state
    always_comb
    begin
        state_next    = state_reg;
        char_next     = char_reg;
        out_load      = 1'b0;
        out_char_next = out_char_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && char_go)
                begin
                    char_next  = char_val;
                    state_next = ST_CHAR;
                end
                else if (accept && num_go)
                    state_next = ST_NUM;
            end
            ST_CHAR:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = char_reg;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_NUM:
            begin
                if (slot_free && num_out.valid)
                begin
                    out_load      = 1'b1;
                    out_char_next = num_out.ch;
                    last_next     = num_out.last;
                    if (num_out.last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NORMAL;
            len_reg       <= LEN_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

FILE: design/pfi_checker.sv
module pfi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  fmt_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_char,
    input logic        last
);

    // Hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled output transaction changed");

    // Block input while a byte still has characters to come
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
    else $error("input accepted before last character of previous byte");

    // Show only a final character right after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid || last)
    else $error("non-final character pending after input accepted");

    // Take a zero byte without any work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (fmt_byte == pfi_pkg::CH_NUL) |=> in_ready)
    else $error("zero byte caused work");

endmodule

bind printf_format_interpreter_unit pfi_checker u_pfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .fmt_byte  (fmt_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
);

FILE: tb/sv/printf_format_interpreter_unit_tb.sv
module printf_format_interpreter_unit_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_EVERY  = 45;

    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] SPEC_CHARS [9] =
        '{pfi_pkg::CH_C, pfi_pkg::CH_PERCENT, pfi_pkg::CH_D, pfi_pkg::CH_I, pfi_pkg::CH_U,
          pfi_pkg::CH_X, pfi_pkg::CH_XUP, pfi_pkg::CH_P, pfi_pkg::CH_O};

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_PCT,
        PH_SHORT,
        PH_LONG,
        PH_SPEC
    } fmt_phase_e;

    typedef enum logic [2:0] {
        LEN_INT,
        LEN_HH,
        LEN_H,
        LEN_L,
        LEN_LL
    } fmt_len_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } emitted_t;

    typedef struct {
        logic [7:0]  fmt;
        logic [63:0] arg;
        bit          typed;
        string       text;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  fmt_byte;
    logic [63:0] arg_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        last;

    // Formatter model state
    fmt_phase_e  fmt_phase;
    fmt_len_e    fmt_len;
    logic [7:0]  step_chars[$];
    emitted_t    expected_chars[$];
    stim_row_t   stim_table[$];

    int cycle_count   = 0;
    int error_count   = 0;
    int items_sent    = 0;
    int chars_checked = 0;
    int specs_seen    = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    printf_format_interpreter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_byte  (fmt_byte),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_chars.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Print a masked integer argument in the given radix
    function automatic void emit_number(input logic [63:0] arg, input pfi_pkg::radix_t radix,
                                        input bit is_signed);
        int          w;
        int unsigned base;
        logic [63:0] mask;
        logic [63:0] v;
        logic [7:0]  digits[$];
        string       digit_set;
        digit_set = "0123456789abcdef";
        if (fmt_len == LEN_LL)
            w = 64;
        else if (fmt_len == LEN_L)
            w = pfi_pkg::LONG_BITS;
        else
            w = pfi_pkg::INT_BITS;
        mask = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
        v = arg & mask;
        if (is_signed && v[w-1])
        begin
            step_chars.push_back(pfi_pkg::CH_MINUS);
            v = (~v + 64'd1) & mask;
        end
        case (radix)
            pfi_pkg::RADIX_DEC: base = 10;
            pfi_pkg::RADIX_HEX: base = 16;
            default:            base = 8;
        endcase
        if (v == 64'd0)
            step_chars.push_back(pfi_pkg::CH_ZERO);
        else
        begin
            while (v != 64'd0)
            begin
                digits.push_front(digit_set[int'(v % base)]);
                v = v / base;
            end
            foreach (digits[i])
                step_chars.push_back(digits[i]);
        end
    endfunction

    // Resolve a conversion letter, then return to plain text
    function automatic void finish_conversion(input logic [7:0] b, input logic [63:0] arg);
        specs_seen++;
        case (b)
            pfi_pkg::CH_C:
                step_chars.push_back(arg[7:0]);
            pfi_pkg::CH_PERCENT:
                step_chars.push_back(pfi_pkg::CH_PERCENT);
            pfi_pkg::CH_D, pfi_pkg::CH_I:
                emit_number(arg, pfi_pkg::RADIX_DEC, 1'b1);
            pfi_pkg::CH_U:
                emit_number(arg, pfi_pkg::RADIX_DEC, 1'b0);
            pfi_pkg::CH_X, pfi_pkg::CH_XUP, pfi_pkg::CH_P:
                emit_number(arg, pfi_pkg::RADIX_HEX, 1'b0);
            pfi_pkg::CH_O:
                emit_number(arg, pfi_pkg::RADIX_OCT, 1'b0);
            default: ;
        endcase
        fmt_phase = PH_TEXT;
        fmt_len   = LEN_INT;
    endfunction

    // Compute the characters one format byte produces
    function automatic void predict_chars(input logic [7:0] b, input logic [63:0] arg);
        step_chars.delete();
        if (b == pfi_pkg::CH_NUL)
        begin
            fmt_phase = PH_TEXT;
            fmt_len   = LEN_INT;
            return;
        end
        case (fmt_phase)
            PH_PCT:
                if (b == pfi_pkg::CH_H)
                begin
                    fmt_len   = LEN_H;
                    fmt_phase = PH_SHORT;
                end
                else if (b == pfi_pkg::CH_L)
                begin
                    fmt_len   = LEN_L;
                    fmt_phase = PH_LONG;
                end
                else
                    finish_conversion(b, arg);
            PH_SHORT:
                if (b == pfi_pkg::CH_H)
                begin
                    fmt_len   = LEN_HH;
                    fmt_phase = PH_SPEC;
                end
                else
                    finish_conversion(b, arg);
            PH_LONG:
                if (b == pfi_pkg::CH_L)
                begin
                    fmt_len   = LEN_LL;
                    fmt_phase = PH_SPEC;
                end
                else
                    finish_conversion(b, arg);
            PH_SPEC:
                finish_conversion(b, arg);
            default:
                if (b == pfi_pkg::CH_PERCENT)
                    fmt_phase = PH_PCT;
                else
                    step_chars.push_back(b);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_arg();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'($urandom_range(0, 999));
            2:       return {$urandom, 32'h8000_0000};
            3:       return {64{1'b1}};
            4:       return 64'h8000_0000_0000_0000;
            5:       return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_row(input logic [7:0] b, input logic [63:0] arg,
                           input bit typed, input string text);
        stim_row_t row;
        row.fmt   = b;
        row.arg   = arg;
        row.typed = typed;
        row.text  = text;
        stim_table.push_back(row);
    endtask

    // Drive one transaction, then queue its expected characters
    task automatic send_item(input logic [7:0] b, input logic [63:0] arg,
                             input bit typed = 1'b0, input string text = "");
        int       gap;
        emitted_t e;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        fmt_byte  <= b;
        arg_value <= arg;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_chars(b, arg);
        if (typed)
        begin
            step_chars.delete();
            for (int i = 0; i < text.len(); i++)
                step_chars.push_back(text[i]);
        end
        foreach (step_chars[i])
        begin
            e.ch   = step_chars[i];
            e.last = (i == step_chars.size() - 1);
            expected_chars.push_back(e);
        end
    endtask

    // Hold off the sender until every queued character has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, mostly short, a few long
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (receiver_steady || $urandom_range(0, 99) < 60)
            begin
                out_ready <= 1'b1;
                hold = $urandom_range(0, 8);
            end
            else
            begin
                out_ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 3);
            end
        end
    end

    // Compare each output transaction with the oldest expected character
    always @(posedge clk)
    begin : check_output
        emitted_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected char 8'h%02h last=%0b", out_char, last));
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (out_char !== want.ch)
                    report_mismatch($sformatf("out_char 8'h%02h, want 8'h%02h",
                                              out_char, want.ch));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b on char 8'h%02h",
                                              last, want.last, want.ch));
            end
        end
    end

    initial
    begin
        int            directed_items;
        int            random_sent;
        int            next_drain;
        int            pick;
        logic [7:0]    b;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        fmt_byte  = 8'h00;
        arg_value = 64'd0;
        fmt_phase = PH_TEXT;
        fmt_len   = LEN_INT;

        // Directed rows: plain text, every spec but %x, width and sign extremes
        add_row("A", 64'd0, 1'b1, "A");
        add_row(8'hFF, {64{1'b1}}, 1'b0, "");
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "%");
        // %c with a zero low byte
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_C, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, "");
        // most negative int
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_I, 64'hFFFF_FFFF_8000_0000, 1'b1, "-2147483648");
        // most negative long long
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_L, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_L, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_D, 64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808");
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_O, {64{1'b1}}, 1'b1, "37777777777");
        // zero value
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_U, 64'd0, 1'b1, "0");
        // hh keeps int width, upper-case X prints lowercase
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_H, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_H, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_XUP, 64'h1234_5678_FFFF_FFFF, 1'b1, "ffffffff");
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_P, 64'hA5A5_A5A5_0123_4567, 1'b0, "");
        // invalid spec
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(CH_S, {64{1'b1}}, 1'b1, "");
        // zero byte mid-conversion, then the letter is plain text
        add_row(pfi_pkg::CH_PERCENT, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_L, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_NUL, 64'd0, 1'b1, "");
        add_row(pfi_pkg::CH_X, {64{1'b1}}, 1'b1, "x");

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
            send_item(stim_table[i].fmt, stim_table[i].arg,
                      stim_table[i].typed, stim_table[i].text);
        directed_items = items_sent;
        wait_drained();

        // Random format strings: mostly well-formed conversions
        next_drain = DRAIN_EVERY;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            sender_steady   = (random_sent >= 40 && random_sent < 60);
            receiver_steady = (random_sent >= 70 && random_sent < 95);
            if (random_sent >= next_drain)
            begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == pfi_pkg::CH_PERCENT)
                    b = "A";
                send_item(b, rand_arg());
            end
            else if (pick < 85)
            begin
                send_item(pfi_pkg::CH_PERCENT, rand_arg());
                case ($urandom_range(0, 4))
                    1: send_item(pfi_pkg::CH_H, rand_arg());
                    2:
                    begin
                        send_item(pfi_pkg::CH_H, rand_arg());
                        send_item(pfi_pkg::CH_H, rand_arg());
                    end
                    3: send_item(pfi_pkg::CH_L, rand_arg());
                    4:
                    begin
                        send_item(pfi_pkg::CH_L, rand_arg());
                        send_item(pfi_pkg::CH_L, rand_arg());
                    end
                    default: ;
                endcase
                send_item(SPEC_CHARS[$urandom_range(0, 8)], rand_arg());
            end
            else if (pick < 93)
            begin
                // broken sequences: third modifier, mixed modifiers, stray letters
                send_item(pfi_pkg::CH_PERCENT, rand_arg());
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_item(pfi_pkg::CH_H, rand_arg());
                        send_item(pfi_pkg::CH_H, rand_arg());
                        send_item(pfi_pkg::CH_H, rand_arg());
                    end
                    1:
                    begin
                        send_item(pfi_pkg::CH_L, rand_arg());
                        send_item(pfi_pkg::CH_L, rand_arg());
                        send_item(pfi_pkg::CH_L, rand_arg());
                    end
                    2:
                    begin
                        send_item(pfi_pkg::CH_H, rand_arg());
                        send_item(pfi_pkg::CH_L, rand_arg());
                    end
                    default: send_item(8'($urandom_range(1, 255)), rand_arg());
                endcase
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                    send_item(pfi_pkg::CH_PERCENT, rand_arg());
                if ($urandom_range(0, 1) == 1)
                    send_item(pfi_pkg::CH_L, rand_arg());
                send_item(pfi_pkg::CH_NUL, rand_arg());
            end
            random_sent = items_sent - directed_items;
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        // Let the last characters out, then watch for strays
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d format bytes (%0d directed), resolved %0d specs, checked %0d chars",
                 items_sent, directed_items, specs_seen, chars_checked);
        $display("Covered all length modifiers and spec letters, invalid specs, zero bytes %s",
                 "and sign/width extremes under random stalls");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
